[sv/btpc_pkg.sv]
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants for the barometric temperature/pressure
// compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

   // input word
   typedef struct packed {
      logic [15:0] raw_temp;
      logic [18:0] raw_pressure;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [15:0] temperature;
      logic [19:0]        pressure;
      logic               status;
   } rsp_type;

   // decoded calibration coefficients and oversampling
   typedef struct packed {
      logic signed [15:0] ac1;
      logic signed [15:0] ac2;
      logic signed [15:0] ac3;
      logic [15:0]        ac4;
      logic [15:0]        ac5;
      logic [15:0]        ac6;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] mc;
      logic signed [15:0] md;
      logic [1:0]         oss;
   } coef_type;

   // word held in the queue between front and back
   typedef struct packed {
      logic signed [33:0] prod;
      logic [18:0]        raw_pressure;
   } fq_type;

   typedef enum logic [1:0] {
      CSR_CAL_A        = 2'd0,
      CSR_CAL_B        = 2'd1,
      CSR_CAL_C        = 2'd2,
      CSR_OVERSAMPLING = 2'd3
   } csr_index_type;

   localparam int FQ_DEPTH = 4;
   localparam int RSP_W    = $bits(rsp_type);

   localparam logic signed [27:0] TEMP_OFFSET = 28'sd4000;
   localparam logic [11:0]        POLY_SQ     = 12'd3038;
   localparam logic signed [14:0] POLY_LIN    = -15'sd7357;
   localparam logic signed [21:0] POLY_OFS    = 22'sd3791;
   localparam logic [16:0]        PRESS_SCALE = 17'd50000;
   localparam logic [31:0]        B4_BIAS     = 32'd32768;
   localparam logic [1:0]         OSS_RESET   = 2'd3;

endpackage

[sv/btpc_ram.sv]
// ----------------------------------------------------------------------------
// btpc_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module btpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/btpc_div.sv]
// ----------------------------------------------------------------------------
// btpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// tag that travels alongside.
// ----------------------------------------------------------------------------
module btpc_div #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 18,
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [NUM_W-1:0] quo,
   output logic [TAG_W-1:0] out_tag
);

   logic             v_ff   [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];   // numerator shifts out, quotient shifts in
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [TAG_W-1:0] tag_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic             v_prev;
      logic [DEN_W-1:0] rem_prev;
      logic [NUM_W-1:0] nq_prev;
      logic [DEN_W-1:0] den_prev;
      logic [TAG_W-1:0] tag_prev;
      logic [DEN_W:0]   trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign v_prev   = in_valid;
         assign rem_prev = '0;
         assign nq_prev  = num;
         assign den_prev = den;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign v_prev   = v_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign tag_prev = tag_ff[k-1];
      end

      assign trial = {rem_prev, nq_prev[NUM_W-1]};
      assign ge    = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
         nq_ff[k]  <= {nq_prev[NUM_W-2:0], ge};
         den_ff[k] <= den_prev;
         tag_ff[k] <= tag_prev;
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign quo       = nq_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

[sv/btpc_front.sv]
// ----------------------------------------------------------------------------
// btpc_front
// Input stage: takes raw words, forms the first temperature product and
// parks the result in a short queue for the back end.
// ----------------------------------------------------------------------------
module btpc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  btpc_pkg::req_type   req_data,
   input  btpc_pkg::coef_type  coef,
   input  logic                fq_pop,
   output logic                fq_valid,
   output btpc_pkg::fq_type    fq_data
);

   localparam int PTR_W = $clog2(btpc_pkg::FQ_DEPTH);
   localparam int CNT_W = $clog2(btpc_pkg::FQ_DEPTH + 1);

   logic              va_ff;
   btpc_pkg::req_type ra_ff;
   btpc_pkg::fq_type  mem_ff [btpc_pkg::FQ_DEPTH];
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  occ_sum;
   logic              accept;
   logic signed [16:0] diff;
   logic signed [33:0] prod;

   // word in the input register counts against queue space
   assign occ_sum = cnt_ff + {{(CNT_W-1){1'b0}}, va_ff};
   assign full    = occ_sum >= CNT_W'(btpc_pkg::FQ_DEPTH);
   assign accept  = push & ~full;

   assign diff = $signed({1'b0, ra_ff.raw_temp}) - $signed({1'b0, coef.ac6});
   assign prod = diff * $signed({1'b0, coef.ac5});

   always_comb begin
      wp_in  = wp_ff + PTR_W'(va_ff);
      rp_in  = rp_ff + PTR_W'(fq_pop);
      cnt_in = cnt_ff + CNT_W'(va_ff) - CNT_W'(fq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff  <= 1'b0;
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         va_ff  <= accept;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ra_ff <= req_data;
      end
      if (va_ff) begin
         mem_ff[wp_ff] <= '{prod: prod, raw_pressure: ra_ff.raw_pressure};
      end
   end

   assign fq_valid = cnt_ff != '0;
   assign fq_data  = mem_ff[rp_ff];

endmodule

[sv/btpc_back.sv]
// ----------------------------------------------------------------------------
// btpc_back
// Free-running compensation pipeline: temperature division, B6/B3/B4/B7
// terms, pressure division and the final polynomial with saturation.
// ----------------------------------------------------------------------------
module btpc_back (
   input  logic               clock,
   input  logic               reset,
   input  btpc_pkg::coef_type coef,
   input  logic               in_valid,
   input  btpc_pkg::fq_type   in_data,
   output logic               out_valid,
   output btpc_pkg::rsp_type  out_data
);

   typedef struct packed {
      logic signed [18:0] x1;
      logic [18:0]        up;
      logic               dz;
      logic               neg;
   } t1_type;

   typedef struct packed {
      logic signed [15:0] t;
      logic               z;
      logic               b7_hi;
   } t2_type;

   // ---- S0: X1 and temperature divisor
   logic               s0_v_ff;
   logic signed [18:0] s0_x1_ff;
   logic signed [19:0] s0_d_ff;
   logic [18:0]        s0_up_ff;
   logic signed [18:0] x1_c;
   logic signed [19:0] d_c;

   assign x1_c = in_data.prod[33:15];
   assign d_c  = $signed({x1_c[18], x1_c}) + $signed({{4{coef.md[15]}}, coef.md});

   always_ff @(posedge clock) begin
      if (reset) s0_v_ff <= 1'b0;
      else       s0_v_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      s0_x1_ff <= x1_c;
      s0_d_ff  <= d_c;
      s0_up_ff <= in_data.raw_pressure;
   end

   // ---- division X2 = MC*2048 / (X1+MD), on magnitudes
   logic [16:0] mc_abs;
   logic [19:0] d_abs;
   t1_type      tag1_in, tag1_out;
   logic        d1_v;
   logic [26:0] q1;

   assign mc_abs = coef.mc[15] ? (17'd0 - {coef.mc[15], coef.mc}) : {1'b0, coef.mc};
   assign d_abs  = s0_d_ff[19] ? (20'd0 - s0_d_ff) : s0_d_ff;
   assign tag1_in = '{x1: s0_x1_ff, up: s0_up_ff, dz: (s0_d_ff == '0),
                      neg: coef.mc[15] ^ s0_d_ff[19]};

   btpc_div #(.NUM_W(27), .DEN_W(18), .TAG_W($bits(t1_type))) u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_v_ff),
      .num       ({mc_abs[15:0], 11'd0}),
      .den       (d_abs[17:0]),
      .in_tag    (tag1_in),
      .out_valid (d1_v),
      .quo       (q1),
      .out_tag   (tag1_out)
   );

   // ---- S1: B5
   logic               s1_v_ff;
   logic signed [27:0] s1_b5_ff;
   logic [18:0]        s1_up_ff;
   logic               s1_dz_ff;
   logic signed [27:0] x2_c;

   assign x2_c = tag1_out.neg ? (28'sd0 - $signed({1'b0, q1})) : $signed({1'b0, q1});

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else       s1_v_ff <= d1_v;
   end
   always_ff @(posedge clock) begin
      s1_b5_ff <= $signed({{9{tag1_out.x1[18]}}, tag1_out.x1}) + x2_c;
      s1_up_ff <= tag1_out.up;
      s1_dz_ff <= tag1_out.dz;
   end

   // ---- S2: temperature out, B6
   logic               s2_v_ff;
   logic signed [15:0] s2_t_ff;
   logic signed [27:0] s2_b6_ff;
   logic [18:0]        s2_up_ff;
   logic               s2_dz_ff;
   logic signed [27:0] tp_c;
   logic [23:0]        tsh_c;
   logic signed [15:0] tsat_c;

   assign tp_c  = s1_b5_ff + 28'sd8;
   assign tsh_c = tp_c[27:4];
   always_comb begin
      if ((&tsh_c[23:15]) | ~(|tsh_c[23:15])) begin
         tsat_c = tsh_c[15:0];
      end else if (tsh_c[23]) begin
         tsat_c = 16'sh8000;
      end else begin
         tsat_c = 16'sh7FFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else       s2_v_ff <= s1_v_ff;
   end
   always_ff @(posedge clock) begin
      s2_t_ff  <= tsat_c;
      s2_b6_ff <= s1_b5_ff - btpc_pkg::TEMP_OFFSET;
      s2_up_ff <= s1_up_ff;
      s2_dz_ff <= s1_dz_ff;
   end

   // ---- S3: B6 squared, AC2*B6, AC3*B6
   logic               s3_v_ff;
   logic signed [55:0] s3_sqp_ff;
   logic signed [43:0] s3_a2p_ff, s3_a3p_ff;
   logic signed [15:0] s3_t_ff;
   logic [18:0]        s3_up_ff;
   logic               s3_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else       s3_v_ff <= s2_v_ff;
   end
   always_ff @(posedge clock) begin
      s3_sqp_ff <= s2_b6_ff * s2_b6_ff;
      s3_a2p_ff <= $signed(coef.ac2) * s2_b6_ff;
      s3_a3p_ff <= $signed(coef.ac3) * s2_b6_ff;
      s3_t_ff   <= s2_t_ff;
      s3_up_ff  <= s2_up_ff;
      s3_dz_ff  <= s2_dz_ff;
   end

   // ---- S4: shifted terms
   logic               s4_v_ff;
   logic [41:0]        s4_sq_ff;
   logic signed [32:0] s4_a2_ff;
   logic signed [30:0] s4_a3_ff;
   logic signed [15:0] s4_t_ff;
   logic [18:0]        s4_up_ff;
   logic               s4_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else       s4_v_ff <= s3_v_ff;
   end
   always_ff @(posedge clock) begin
      s4_sq_ff <= s3_sqp_ff[53:12];
      s4_a2_ff <= s3_a2p_ff[43:11];
      s4_a3_ff <= s3_a3p_ff[43:13];
      s4_t_ff  <= s3_t_ff;
      s4_up_ff <= s3_up_ff;
      s4_dz_ff <= s3_dz_ff;
   end

   // ---- S5: B2*sq and B1*sq as split partial products
   logic               s5_v_ff;
   logic signed [37:0] s5_m2l_ff, s5_m2h_ff, s5_m1l_ff, s5_m1h_ff;
   logic signed [32:0] s5_a2_ff;
   logic signed [30:0] s5_a3_ff;
   logic signed [15:0] s5_t_ff;
   logic [18:0]        s5_up_ff;
   logic               s5_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else       s5_v_ff <= s4_v_ff;
   end
   always_ff @(posedge clock) begin
      s5_m2l_ff <= $signed(coef.b2) * $signed({1'b0, s4_sq_ff[20:0]});
      s5_m2h_ff <= $signed(coef.b2) * $signed({1'b0, s4_sq_ff[41:21]});
      s5_m1l_ff <= $signed(coef.b1) * $signed({1'b0, s4_sq_ff[20:0]});
      s5_m1h_ff <= $signed(coef.b1) * $signed({1'b0, s4_sq_ff[41:21]});
      s5_a2_ff  <= s4_a2_ff;
      s5_a3_ff  <= s4_a3_ff;
      s5_t_ff   <= s4_t_ff;
      s5_up_ff  <= s4_up_ff;
      s5_dz_ff  <= s4_dz_ff;
   end

   // ---- S6: recombine partial products
   logic               s6_v_ff;
   logic [58:0]        s6_b2sq_ff, s6_b1sq_ff;
   logic signed [32:0] s6_a2_ff;
   logic signed [30:0] s6_a3_ff;
   logic signed [15:0] s6_t_ff;
   logic [18:0]        s6_up_ff;
   logic               s6_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) s6_v_ff <= 1'b0;
      else       s6_v_ff <= s5_v_ff;
   end
   always_ff @(posedge clock) begin
      s6_b2sq_ff <= {s5_m2h_ff, 21'd0} + {{21{s5_m2l_ff[37]}}, s5_m2l_ff};
      s6_b1sq_ff <= {s5_m1h_ff, 21'd0} + {{21{s5_m1l_ff[37]}}, s5_m1l_ff};
      s6_a2_ff   <= s5_a2_ff;
      s6_a3_ff   <= s5_a3_ff;
      s6_t_ff    <= s5_t_ff;
      s6_up_ff   <= s5_up_ff;
      s6_dz_ff   <= s5_dz_ff;
   end

   // ---- S7: X3 for B3 (full width) and for B4 (low 32 bits only)
   logic               s7_v_ff;
   logic [48:0]        s7_x3a_ff;
   logic [31:0]        s7_x3c_ff;
   logic signed [15:0] s7_t_ff;
   logic [18:0]        s7_up_ff;
   logic               s7_dz_ff;
   logic [43:0]        x3c_sum;

   assign x3c_sum = {{13{s6_a3_ff[30]}}, s6_a3_ff} + {s6_b1sq_ff[58], s6_b1sq_ff[58:16]}
                    + 44'd2;

   always_ff @(posedge clock) begin
      if (reset) s7_v_ff <= 1'b0;
      else       s7_v_ff <= s6_v_ff;
   end
   always_ff @(posedge clock) begin
      s7_x3a_ff <= {s6_b2sq_ff[58], s6_b2sq_ff[58:11]} + {{16{s6_a2_ff[32]}}, s6_a2_ff};
      s7_x3c_ff <= x3c_sum[33:2];
      s7_t_ff   <= s6_t_ff;
      s7_up_ff  <= s6_up_ff;
      s7_dz_ff  <= s6_dz_ff;
   end

   // ---- S8: B3 numerator, B4 product
   logic               s8_v_ff;
   logic [53:0]        s8_v3_ff;
   logic [31:0]        s8_b4p_ff;
   logic signed [15:0] s8_t_ff;
   logic [18:0]        s8_up_ff;
   logic               s8_dz_ff;
   logic [49:0]        b3s;
   logic [53:0]        b3v;
   logic [47:0]        b4_full;

   assign b3s     = {{32{coef.ac1[15]}}, coef.ac1, 2'b00} + {s7_x3a_ff[48], s7_x3a_ff};
   assign b3v     = ({{4{b3s[49]}}, b3s} << coef.oss) + 54'd2;
   assign b4_full = coef.ac4 * (s7_x3c_ff + btpc_pkg::B4_BIAS);

   always_ff @(posedge clock) begin
      if (reset) s8_v_ff <= 1'b0;
      else       s8_v_ff <= s7_v_ff;
   end
   always_ff @(posedge clock) begin
      s8_v3_ff  <= b3v;
      s8_b4p_ff <= b4_full[31:0];
      s8_t_ff   <= s7_t_ff;
      s8_up_ff  <= s7_up_ff;
      s8_dz_ff  <= s7_dz_ff;
   end

   // ---- S9: B3 = numerator/4 rounded toward zero, B4
   logic               s9_v_ff;
   logic [31:0]        s9_b3_ff;
   logic [16:0]        s9_b4_ff;
   logic               s9_z_ff;
   logic signed [15:0] s9_t_ff;
   logic [18:0]        s9_up_ff;

   always_ff @(posedge clock) begin
      if (reset) s9_v_ff <= 1'b0;
      else       s9_v_ff <= s8_v_ff;
   end
   always_ff @(posedge clock) begin
      s9_b3_ff <= s8_v3_ff[33:2]
                  + {31'd0, s8_v3_ff[53] & (s8_v3_ff[1:0] != 2'b00)};
      s9_b4_ff <= s8_b4p_ff[31:15];
      s9_z_ff  <= s8_dz_ff | (s8_b4p_ff[31:15] == '0);
      s9_t_ff  <= s8_t_ff;
      s9_up_ff <= s8_up_ff;
   end

   // ---- S10: B7
   logic               s10_v_ff;
   logic [31:0]        s10_b7_ff;
   logic [16:0]        s10_b4_ff;
   logic               s10_z_ff;
   logic signed [15:0] s10_t_ff;
   logic [15:0]        scale;
   logic [47:0]        b7_full;

   assign scale   = 16'(btpc_pkg::PRESS_SCALE >> coef.oss);
   assign b7_full = ({13'd0, s9_up_ff} - s9_b3_ff) * scale;

   always_ff @(posedge clock) begin
      if (reset) s10_v_ff <= 1'b0;
      else       s10_v_ff <= s9_v_ff;
   end
   always_ff @(posedge clock) begin
      s10_b7_ff <= b7_full[31:0];
      s10_b4_ff <= s9_b4_ff;
      s10_z_ff  <= s9_z_ff;
      s10_t_ff  <= s9_t_ff;
   end

   // ---- pressure division; large B7 is divided first and doubled after
   t2_type      tag2_in, tag2_out;
   logic        d2_v;
   logic [31:0] q2;

   assign tag2_in = '{t: s10_t_ff, z: s10_z_ff, b7_hi: s10_b7_ff[31]};

   btpc_div #(.NUM_W(32), .DEN_W(17), .TAG_W($bits(t2_type))) u_div_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s10_v_ff),
      .num       (s10_b7_ff[31] ? s10_b7_ff : {s10_b7_ff[30:0], 1'b0}),
      .den       (s10_b4_ff),
      .in_tag    (tag2_in),
      .out_valid (d2_v),
      .quo       (q2),
      .out_tag   (tag2_out)
   );

   // ---- S11: polynomial products; p at or above 2^20 always saturates
   logic               s11_v_ff;
   logic [23:0]        s11_pp_ff;
   logic signed [34:0] s11_lin_ff;
   logic [19:0]        s11_pl_ff;
   logic               s11_big_ff;
   logic               s11_z_ff;
   logic signed [15:0] s11_t_ff;
   logic [32:0]        p33;

   assign p33 = tag2_out.b7_hi ? {q2, 1'b0} : {1'b0, q2};

   always_ff @(posedge clock) begin
      if (reset) s11_v_ff <= 1'b0;
      else       s11_v_ff <= d2_v;
   end
   always_ff @(posedge clock) begin
      s11_pp_ff  <= p33[19:8] * p33[19:8];
      s11_lin_ff <= btpc_pkg::POLY_LIN * $signed({1'b0, p33[19:0]});
      s11_pl_ff  <= p33[19:0];
      s11_big_ff <= |p33[32:20];
      s11_z_ff   <= tag2_out.z;
      s11_t_ff   <= tag2_out.t;
   end

   // ---- S12: scaled polynomial terms
   logic               s12_v_ff;
   logic [19:0]        s12_x1_ff;
   logic signed [18:0] s12_x2_ff;
   logic [19:0]        s12_pl_ff;
   logic               s12_big_ff;
   logic               s12_z_ff;
   logic signed [15:0] s12_t_ff;
   logic [35:0]        x1p_full;

   assign x1p_full = s11_pp_ff * btpc_pkg::POLY_SQ;

   always_ff @(posedge clock) begin
      if (reset) s12_v_ff <= 1'b0;
      else       s12_v_ff <= s11_v_ff;
   end
   always_ff @(posedge clock) begin
      s12_x1_ff  <= x1p_full[35:16];
      s12_x2_ff  <= s11_lin_ff[34:16];
      s12_pl_ff  <= s11_pl_ff;
      s12_big_ff <= s11_big_ff;
      s12_z_ff   <= s11_z_ff;
      s12_t_ff   <= s11_t_ff;
   end

   // ---- S13: correction, saturation, result word
   logic               s13_v_ff;
   btpc_pkg::rsp_type  s13_data_ff;
   logic signed [21:0] corr_sum;
   logic signed [21:0] pres;
   logic [19:0]        psat;

   assign corr_sum = $signed({2'b00, s12_x1_ff}) + $signed({{3{s12_x2_ff[18]}}, s12_x2_ff})
                     + btpc_pkg::POLY_OFS;
   assign pres     = $signed({2'b00, s12_pl_ff}) + $signed({{4{corr_sum[21]}}, corr_sum[21:4]});

   always_comb begin
      if (s12_big_ff) begin
         psat = 20'hFFFFF;
      end else if (pres[21]) begin
         psat = '0;
      end else if (pres[20]) begin
         psat = 20'hFFFFF;
      end else begin
         psat = pres[19:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s13_v_ff <= 1'b0;
      else       s13_v_ff <= s12_v_ff;
   end
   always_ff @(posedge clock) begin
      if (s12_z_ff) begin
         s13_data_ff <= '{temperature: '0, pressure: '0, status: 1'b1};
      end else begin
         s13_data_ff <= '{temperature: s12_t_ff, pressure: psat, status: 1'b0};
      end
   end

   assign out_valid = s13_v_ff;
   assign out_data  = s13_data_ff;

endmodule

[sv/barometer_temp_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// barometer_temp_pressure_compensation
// Integer temperature/pressure compensation from raw sensor words.
// Two restoring dividers (27 and 32 stages, one quotient bit each) form most of
// the pipeline. Throughput: one word per cycle in steady state, while the result
// queue has room, i.e. while pop keeps up; results queue in a RAM.
// Reset: clears all control state, calibration words to 0, oversampling to 3.
// No clearing pass; push is taken from the cycle after reset.
// ----------------------------------------------------------------------------
module barometer_temp_pressure_compensation #(
   parameter int OUT_DEPTH = 128   // power of two, above the pipeline length
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  btpc_pkg::req_type  req_data,
   output logic               empty,
   input  logic               pop,
   output btpc_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   localparam int AW    = $clog2(OUT_DEPTH);
   localparam int OCC_W = $clog2(OUT_DEPTH + 1);

   // ---- configuration
   logic [63:0] cal_a_ff, cal_b_ff;
   logic [31:0] cal_c_ff;
   logic [1:0]  oss_ff;
   btpc_pkg::coef_type coef;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
         oss_ff   <= btpc_pkg::OSS_RESET;
      end else if (csr_valid) begin
         case (btpc_pkg::csr_index_type'(csr_index))
            btpc_pkg::CSR_CAL_A:        cal_a_ff <= csr_wdata;
            btpc_pkg::CSR_CAL_B:        cal_b_ff <= csr_wdata;
            btpc_pkg::CSR_CAL_C:        cal_c_ff <= csr_wdata[31:0];
            btpc_pkg::CSR_OVERSAMPLING: oss_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign coef = '{ac1: cal_a_ff[63:48], ac2: cal_a_ff[47:32], ac3: cal_a_ff[31:16],
                   ac4: cal_a_ff[15:0],  ac5: cal_b_ff[63:48], ac6: cal_b_ff[47:32],
                   b1:  cal_b_ff[31:16], b2:  cal_b_ff[15:0],
                   mc:  cal_c_ff[31:16], md:  cal_c_ff[15:0],  oss: oss_ff};

   // ---- front and back
   logic              fq_valid, fq_pop, credit_ok;
   btpc_pkg::fq_type  fq_data;
   logic              back_valid;
   btpc_pkg::rsp_type back_data;

   btpc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .coef     (coef),
      .fq_pop   (fq_pop),
      .fq_valid (fq_valid),
      .fq_data  (fq_data)
   );

   // words only enter the back end when the result queue has room reserved
   assign fq_pop = fq_valid & credit_ok;

   btpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .in_valid  (fq_pop),
      .in_data   (fq_data),
      .out_valid (back_valid),
      .out_data  (back_data)
   );

   // ---- result queue; RAM read register doubles as the output register
   logic [AW:0]      wr_ptr_ff, rd_ptr_ff;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             ov_ff, ov_in;
   logic             ram_ne, rd_en;
   logic [btpc_pkg::RSP_W-1:0] ram_rdata;

   assign credit_ok = occ_ff < OCC_W'(OUT_DEPTH);
   assign ram_ne    = wr_ptr_ff != rd_ptr_ff;
   assign rd_en     = ram_ne & (~ov_ff | pop);

   always_comb begin
      occ_in = occ_ff + OCC_W'(fq_pop) - OCC_W'(rd_en);
      ov_in  = rd_en | (ov_ff & ~pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
         ov_ff     <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + (AW+1)'(back_valid);
         rd_ptr_ff <= rd_ptr_ff + (AW+1)'(rd_en);
         occ_ff    <= occ_in;
         ov_ff     <= ov_in;
      end
   end

   btpc_ram #(.WIDTH(btpc_pkg::RSP_W), .DEPTH(OUT_DEPTH)) u_rsp_ram (
      .clock   (clock),
      .wr_en   (back_valid),
      .wr_addr (wr_ptr_ff[AW-1:0]),
      .wr_data (back_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign empty    = ~ov_ff;
   assign rsp_data = btpc_pkg::rsp_type'(ram_rdata);

   // ---- assertions
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(OUT_DEPTH))
      else $error("result credit count above queue depth");

   a_fill_le_occ: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) <= occ_ff)
      else $error("result RAM holds more words than reserved");

   a_prefetch: assert property (@(posedge clock) disable iff (reset)
      (~ov_ff & ram_ne) |=> ov_ff)
      else $error("stored result not moved to output register");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (back_valid & back_data.status) |->
         (back_data.pressure == '0 && back_data.temperature == '0))
      else $error("error word carries nonzero results");

endmodule

[sim/barometer_temp_pressure_compensation_test.sv]
// ----------------------------------------------------------------------------
// barometer_temp_pressure_compensation_test
// Drives raw temperature/pressure words through several calibration and
// oversampling settings, predicts each compensated word and checks it.
// ----------------------------------------------------------------------------
module barometer_temp_pressure_compensation_test;
   timeunit 1ns;
   timeprecision 1ps;
   import btpc_pkg::*;

   logic          clock;
   logic          reset;
   logic          push;
   logic          full;
   req_type       req_data;
   logic          empty;
   logic          pop;
   rsp_type       rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [63:0]   csr_wdata;

   barometer_temp_pressure_compensation u_top (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor copy of the calibration registers
   logic [63:0] cal_a, cal_b;
   logic [31:0] cal_c;
   logic [1:0]  oss_cfg;

   req_type     raw_words[$];
   rsp_type     comp_words[$];
   int          errors, n_sent, n_checked, n_fault, n_settings;
   int          send_gap, take_gap, idle_cycles;
   bit          no_idle;

   function automatic rsp_type compensate(req_type r);
      longint      ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      longint      ut, x1, x2, x3, b5, b6, b3, t, p, sq, den;
      int unsigned up, ac4w, bias, b3w, b4, b7, quo;
      rsp_type     o;
      ac1 = longint'($signed(cal_a[63:48]));
      ac2 = longint'($signed(cal_a[47:32]));
      ac3 = longint'($signed(cal_a[31:16]));
      ac4 = longint'(cal_a[15:0]);
      ac5 = longint'(cal_b[63:48]);
      ac6 = longint'(cal_b[47:32]);
      b1  = longint'($signed(cal_b[31:16]));
      b2  = longint'($signed(cal_b[15:0]));
      mc  = longint'($signed(cal_c[31:16]));
      md  = longint'($signed(cal_c[15:0]));
      o = '0;
      o.status = 1'b1;
      ut = longint'(r.raw_temp);
      up = 32'(r.raw_pressure);
      x1 = ((ut - ac6) * ac5) >>> 15;
      den = x1 + md;
      if (den == 0) return o;
      x2 = (mc * 2048) / den;
      b5 = x1 + x2;
      t  = (b5 + 8) >>> 4;
      b6 = b5 - 4000;
      sq = (b6 * b6) >>> 12;
      x1 = (b2 * sq) >>> 11;
      x2 = (ac2 * b6) >>> 11;
      x3 = x1 + x2;
      b3 = ((ac1 * 4 + x3) * (longint'(1) << oss_cfg) + 2) / 4;
      x1 = (ac3 * b6) >>> 13;
      x2 = (b1 * sq) >>> 16;
      x3 = (x1 + x2 + 2) >>> 2;
      bias = 32'(x3 + 32768);
      ac4w = 32'(ac4);
      b4 = (ac4w * bias) >> 15;
      if (b4 == 0) return o;
      b3w = 32'(b3);
      b7 = (up - b3w) * (32'd50000 >> oss_cfg);
      if (b7 < 32'h8000_0000) begin
         quo = (b7 * 2) / b4;
         p = longint'(quo);
      end else begin
         quo = b7 / b4;
         p = longint'(quo) * 2;
      end
      x1 = (p >>> 8) * (p >>> 8);
      x1 = (x1 * 3038) >>> 16;
      x2 = (-7357 * p) >>> 16;
      p  = p + ((x1 + x2 + 3791) >>> 4);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      if (p < 0) p = 0;
      if (p > 1048575) p = 1048575;
      o.temperature = t[15:0];
      o.pressure = p[19:0];
      o.status = 1'b0;
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
         req_data <= '0;
         send_gap <= 0;
      end else begin
         if (push && !full) begin
            comp_words.push_back(compensate(req_data));
            void'(raw_words.pop_front());
            n_sent <= n_sent + 1;
         end
         if (!(push && full)) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               push <= 1'b0;
            end else if (raw_words.size() > 0) begin
               push <= 1'b1;
               req_data <= raw_words[0];
               send_gap <= pick_gap();
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
         take_gap <= 0;
      end else begin
         if (pop && !empty) begin
            if (comp_words.size() == 0) begin
               $display("%0t: unexpected word %h", $time, rsp_data);
               errors++;
            end else begin
               want = comp_words.pop_front();
               n_checked++;
               if (want.status) n_fault++;
               if (rsp_data.temperature !== want.temperature) begin
                  $display("%0t: temperature exp %0d got %0d", $time,
                           want.temperature, rsp_data.temperature);
                  errors++;
               end
               if (rsp_data.pressure !== want.pressure) begin
                  $display("%0t: pressure exp %0d got %0d", $time,
                           want.pressure, rsp_data.pressure);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status exp %0d got %0d", $time,
                           want.status, rsp_data.status);
                  errors++;
               end
            end
         end
         if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            take_gap <= pick_gap();
         end
      end
   end

   // watchdog: cycles with no word moving on any port
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == 3000) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CAL_A:        cal_a = val;
         CSR_CAL_B:        cal_b = val;
         CSR_CAL_C:        cal_c = val[31:0];
         CSR_OVERSAMPLING: oss_cfg = val[1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      wait (raw_words.size() == 0 && !push && comp_words.size() == 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_cal(logic [63:0] a, logic [63:0] b, logic [31:0] c, logic [1:0] o);
      write_csr(CSR_CAL_A, a);
      write_csr(CSR_CAL_B, b);
      write_csr(CSR_CAL_C, {32'h0, c});
      write_csr(CSR_OVERSAMPLING, {62'h0, o});
      n_settings++;
   endtask

   task automatic queue_random(int count);
      req_type r;
      repeat (count) begin
         if ($urandom_range(0, 1)) begin
            // plausible readings around a room-temperature sensor
            r.raw_temp = 16'($urandom_range(22000, 34000));
            r.raw_pressure = 19'($urandom_range(20000, 45000) << oss_cfg);
         end else begin
            r.raw_temp = 16'($urandom);
            r.raw_pressure = 19'($urandom);
         end
         raw_words.push_back(r);
      end
   endtask

   localparam logic [63:0] TYP_A = {16'd408, -16'sd72, -16'sd14383, 16'd32741};
   localparam logic [63:0] TYP_B = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
   localparam logic [31:0] TYP_C = {-16'sd8711, 16'sd2868};

   initial begin
      req_type r;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_CAL_A;
      csr_wdata = '0;
      cal_a = '0; cal_b = '0; cal_c = '0; oss_cfg = OSS_RESET;
      errors = 0; n_sent = 0; n_checked = 0; n_fault = 0; n_settings = 0;
      no_idle = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset calibration: temperature divisor is zero for every word
      r = '{raw_temp: 16'h0000, raw_pressure: 19'h00000}; raw_words.push_back(r);
      r = '{raw_temp: 16'hFFFF, raw_pressure: 19'h7FFFF}; raw_words.push_back(r);
      drain();

      // datasheet-like calibration, all oversampling settings, field extremes
      for (int o = 0; o < 4; o++) begin
         set_cal(TYP_A, TYP_B, TYP_C, 2'(o));
         r = '{raw_temp: 16'd27898, raw_pressure: 19'(23843 << o)}; raw_words.push_back(r);
         r = '{raw_temp: 16'h0000, raw_pressure: 19'h7FFFF}; raw_words.push_back(r);
         r = '{raw_temp: 16'hFFFF, raw_pressure: 19'h00000}; raw_words.push_back(r);
         r = '{raw_temp: 16'h8000, raw_pressure: 19'h40000}; raw_words.push_back(r);
         drain();
      end
      // zero B4: AC4 cleared
      set_cal({TYP_A[63:16], 16'd0}, TYP_B, TYP_C, 2'd1);
      r = '{raw_temp: 16'd27898, raw_pressure: 19'd50000}; raw_words.push_back(r);
      drain();
      // temperature divisor zero with nonzero MC: AC5 zero, MD zero
      set_cal(TYP_A, {16'd0, TYP_B[47:0]}, {TYP_C[31:16], 16'd0}, 2'd2);
      r = '{raw_temp: 16'd1234, raw_pressure: 19'd1234}; raw_words.push_back(r);
      drain();
      // extreme coefficients, which can drive the outputs into saturation
      set_cal(64'h7FFF_8000_7FFF_FFFF, 64'hFFFF_0000_8000_7FFF, 32'h7FFF_0001, 2'd0);
      queue_random(10);
      drain();

      // random phases: typical, random, all-ones and partly random calibrations
      for (int ph = 0; ph < 12; ph++) begin
         no_idle = (ph % 4 == 2);
         case (ph % 4)
            0: set_cal(TYP_A, TYP_B, TYP_C, 2'($urandom));
            1: set_cal({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 2'($urandom));
            2: set_cal(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                       32'hFFFF_FFFF, 2'd3);
            default: set_cal({TYP_A[63:16], 16'($urandom)},
                             {16'($urandom), TYP_B[47:0]}, $urandom, 2'($urandom));
         endcase
         queue_random(100);
         drain();
      end

      $display("checked %0d words (%0d with divisor fault) over %0d calibration settings",
               n_checked, n_fault, n_settings);
      if (errors == 0 && comp_words.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
